// ===== hdl/nalsplit_pkg.sv =====
// Package: shared types, constants and header decode for the NAL unit splitter.
package nalsplit_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int IN_TDATA_BITS     = 8;
    localparam int OUT_TDATA_BITS    = 72;

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
    localparam logic [7:0] H265_TYPE_MASK = 8'h7E;

    localparam logic [4:0] H264_NAL_SEI = 5'd6;
    localparam logic [4:0] H264_NAL_SPS = 5'd7;
    localparam logic [4:0] H264_NAL_PPS = 5'd8;

    localparam logic [5:0] H265_NAL_TRAIL_N = 6'd0;
    localparam logic [5:0] H265_NAL_TRAIL_R = 6'd1;
    localparam logic [5:0] H265_NAL_IDR     = 6'd19;
    localparam logic [5:0] H265_NAL_VPS     = 6'd32;
    localparam logic [5:0] H265_NAL_SPS     = 6'd33;
    localparam logic [5:0] H265_NAL_PPS     = 6'd34;

    localparam logic [2:0] PREFIX_SHORT = 3'd3;
    localparam logic [2:0] PREFIX_LONG  = 3'd4;

    typedef enum logic [2:0] {
        UT_OTHER = 3'd0,
        UT_B     = 3'd1,
        UT_IDR   = 3'd2,
        UT_SEI   = 3'd3,
        UT_VPS   = 3'd4,
        UT_SPS   = 3'd5,
        UT_PPS   = 3'd6
    } t_unit_type;

    typedef struct packed {
        logic       run_last;
        t_unit_type unit_type;
        logic [2:0] prefix_len;
        logic [31:0] unit_size;
        logic [31:0] unit_offset;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    d0;
        t_result    d1;
    } t_push;

    function automatic t_unit_type classify(input logic codec, input logic [7:0] b);
        logic [4:0] h4;
        logic [5:0] h5;
        t_unit_type t;
        h4 = 5'(b & H264_TYPE_MASK);
        h5 = 6'((b & H265_TYPE_MASK) >> 1);
        t  = UT_OTHER;
        if (codec == CODEC_H264) begin
            case (h4)
                H264_NAL_SEI: t = UT_SEI;
                H264_NAL_SPS: t = UT_SPS;
                H264_NAL_PPS: t = UT_PPS;
                default:      t = UT_OTHER;
            endcase
        end else begin
            case (h5)
                H265_NAL_TRAIL_N: t = UT_B;
                H265_NAL_TRAIL_R: t = UT_OTHER;
                H265_NAL_IDR:     t = UT_IDR;
                H265_NAL_VPS:     t = UT_VPS;
                H265_NAL_SPS:     t = UT_SPS;
                H265_NAL_PPS:     t = UT_PPS;
                default:          t = UT_OTHER;
            endcase
        end
        return t;
    endfunction

endpackage

// ===== hdl/nalsplit_parser.sv =====
// Start code scanner: unit tracking state and result generation per byte.
module nalsplit_parser
    import nalsplit_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  logic       i_codec,
    output t_push      o_push
);

    localparam int PB = POSITION_BITS;

    logic [1:0]    r_zero_run, n_zero_run;
    logic [PB-1:0] r_pos, n_pos;
    logic [PB-1:0] r_start, n_start;
    logic [2:0]    r_plen, n_plen;
    t_unit_type    r_type, n_type;
    logic          r_open, n_open;
    logic          r_pending, n_pending;

    logic          start_code;
    logic [PB-1:0] sc_start;
    logic [2:0]    sc_plen;
    logic [PB-1:0] pos_inc;
    t_result       res_a, res_b;

    function automatic t_result build(input logic [PB-1:0] start, input logic [PB-1:0] stop,
                                      input logic [2:0] plen, input t_unit_type typ,
                                      input logic last);
        logic [PB-1:0] diff;
        logic [63:0]   diff_ext;
        t_result       r;
        diff          = stop - start;
        diff_ext      = 64'(diff);
        r.unit_offset = 32'(start);
        r.unit_size   = (|diff_ext[63:32]) ? 32'hFFFF_FFFF : diff_ext[31:0];
        r.prefix_len  = plen;
        r.unit_type   = typ;
        r.run_last    = last;
        return r;
    endfunction

    always_comb begin
        start_code = (i_byte == 8'd1) && (r_zero_run >= 2'd2);
        sc_plen    = (r_zero_run == 2'd3) ? PREFIX_LONG : PREFIX_SHORT;
        sc_start   = r_pos - ((r_zero_run == 2'd3) ? PB'(3) : PB'(2));
        pos_inc    = r_pos + PB'(1);

        n_start   = r_start;
        n_plen    = r_plen;
        n_type    = r_type;
        n_open    = r_open;
        n_pending = r_pending;
        if (start_code) begin
            n_start   = sc_start;
            n_plen    = sc_plen;
            n_type    = UT_OTHER;
            n_open    = 1'b1;
            n_pending = 1'b1;
        end else if (r_pending) begin
            n_type    = classify(i_codec, i_byte);
            n_pending = 1'b0;
        end

        res_a = build(r_start, sc_start, r_plen, r_type, !i_end);
        res_b = build(n_start, pos_inc, n_plen, n_type, 1'b1);

        o_push.d0  = res_b;
        o_push.d1  = res_b;
        o_push.cnt = 2'd0;
        if (i_valid) begin
            if (start_code && r_open) begin
                o_push.d0  = res_a;
                o_push.cnt = i_end ? 2'd2 : 2'd1;
            end else begin
                o_push.cnt = (i_end && n_open) ? 2'd1 : 2'd0;
            end
        end

        if (i_byte == 8'd0) begin
            n_zero_run = (r_zero_run == 2'd3) ? r_zero_run : r_zero_run + 2'd1;
        end else begin
            n_zero_run = 2'd0;
        end
        n_pos = pos_inc;

        if (i_end) begin
            n_zero_run = 2'd0;
            n_pos      = '0;
            n_start    = '0;
            n_plen     = PREFIX_SHORT;
            n_type     = UT_OTHER;
            n_open     = 1'b0;
            n_pending  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_pos      <= '0;
            r_start    <= '0;
            r_plen     <= PREFIX_SHORT;
            r_type     <= UT_OTHER;
            r_open     <= 1'b0;
            r_pending  <= 1'b0;
        end else if (i_valid) begin
            r_zero_run <= n_zero_run;
            r_pos      <= n_pos;
            r_start    <= n_start;
            r_plen     <= n_plen;
            r_type     <= n_type;
            r_open     <= n_open;
            r_pending  <= n_pending;
        end
    end

endmodule

// ===== hdl/nalsplit_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per word.
module nalsplit_queue
    import nalsplit_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room2,
    output logic    o_valid,
    output t_result o_head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result       r_q [QUEUE_DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    always_comb begin
        o_valid = (r_count != '0);
        o_head  = r_q[r_head];
        o_room2 = (r_count <= CW'(QUEUE_DEPTH - 2));
        pop     = i_pop && o_valid;
        n_head  = pop ? r_head + AW'(1) : r_head;
        n_tail  = r_tail + AW'(i_push.cnt);
        n_count = r_count + CW'(i_push.cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_tail] <= i_push.d0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[r_tail + AW'(1)] <= i_push.d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/annexb_nal_unit_splitter_top.sv =====
// Top level: input register, start code parser and result queue.
// The parser reads the input register and writes its results into the result queue.
// Throughput: one byte per cycle unless stalled; a byte closing two units makes two words.
// The input register advances only while the result queue has room for two words.
// Reset: synchronous, active low; clears scan state, queue and codec register (H.264).
module annexb_nal_unit_splitter_top
    import nalsplit_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic                      i_s_axis_tlast,   // stream_end
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,   // unit_offset, unit_size,
                                                        // prefix_len, unit_type, zero pad
    output logic                      o_m_axis_tlast    // run_last
);

    logic       r_codec;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       advance;
    logic       room2;
    t_push      push;
    t_result    head;

    assign advance         = r_in_valid && room2;
    assign o_s_axis_tready = !r_in_valid || room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec    <= CODEC_H264;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_codec <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    nalsplit_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_codec (r_codec),
        .o_push  (push)
    );

    nalsplit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_room2 (room2),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head)
    );

    assign o_m_axis_tdata = {2'b00, head.unit_type, head.prefix_len, head.unit_size,
                             head.unit_offset};
    assign o_m_axis_tlast = head.run_last;

endmodule

// ===== hdl/nalsplit_checker.sv =====
// Checker: port-level properties of the NAL unit splitter, bound to the top level.
module nalsplit_checker
    import nalsplit_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tlast
);

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

    a_prefix_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[66:64] == PREFIX_SHORT || o_m_axis_tdata[66:64] == PREFIX_LONG)
        else $error("prefix length not 3 or 4");

    a_unit_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[69:67] <= UT_PPS && o_m_axis_tdata[71:70] == 2'b00)
        else $error("unit type out of range or pad bits set");

endmodule

bind annexb_nal_unit_splitter_top nalsplit_checker u_nalsplit_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== tb/annexb_nal_unit_splitter_top_test.sv =====
// Self-checking testbench for the Annex B NAL unit splitter: directed and random byte streams.
`timescale 1ns / 100ps

module annexb_nal_unit_splitter_top_test;
    import nalsplit_pkg::*;

    typedef logic [7:0] octet_q[$];

    localparam int  TOTAL_BYTES = 1450;
    localparam int  HOLD_CYCLES = 300;
    localparam int  CYCLE_LIMIT = 200000;
    localparam logic [7:0] HDR_BYTES [12] = '{8'h67, 8'h68, 8'h06, 8'h65, 8'h41, 8'hE7,
                                             8'h40, 8'h42, 8'h44, 8'h26, 8'h00, 8'hC1};

    // Tracks the open NAL unit and holds the units expected on the output.
    class unit_scoreboard;
        logic        codec;
        logic [1:0]  zero_run;
        logic [31:0] byte_pos;
        logic [31:0] unit_start;
        logic [2:0]  unit_plen;
        t_unit_type  unit_kind;
        bit          unit_open;
        bit          header_wait;
        t_result     expected_units[$];
        int          failures;

        function new();
            codec    = CODEC_H264;
            failures = 0;
            restart();
        endfunction

        function void restart();
            zero_run    = 2'd0;
            byte_pos    = 32'd0;
            unit_start  = 32'd0;
            unit_plen   = PREFIX_SHORT;
            unit_kind   = UT_OTHER;
            unit_open   = 1'b0;
            header_wait = 1'b0;
        endfunction

        function t_unit_type header_class(logic [7:0] b);
            logic [4:0] h4;
            logic [5:0] h5;
            h4 = b[4:0];
            h5 = b[6:1];
            if (codec == CODEC_H264) begin
                case (h4)
                    H264_NAL_SEI: return UT_SEI;
                    H264_NAL_SPS: return UT_SPS;
                    H264_NAL_PPS: return UT_PPS;
                    default:      return UT_OTHER;
                endcase
            end
            case (h5)
                H265_NAL_TRAIL_N: return UT_B;
                H265_NAL_IDR:     return UT_IDR;
                H265_NAL_VPS:     return UT_VPS;
                H265_NAL_SPS:     return UT_SPS;
                H265_NAL_PPS:     return UT_PPS;
                default:          return UT_OTHER;
            endcase
        endfunction

        function void close_unit(logic [31:0] end_pos);
            t_result r;
            r.unit_offset = unit_start;
            r.unit_size   = end_pos - unit_start;
            r.prefix_len  = unit_plen;
            r.unit_type   = unit_kind;
            r.run_last    = 1'b0;
            expected_units.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            int          n0;
            logic [2:0]  plen;
            logic [31:0] start;
            n0 = expected_units.size();
            if (b == 8'h01 && zero_run >= 2'd2) begin
                plen  = (zero_run == 2'd3) ? PREFIX_LONG : PREFIX_SHORT;
                start = byte_pos - 32'(plen) + 32'd1;
                if (unit_open)
                    close_unit(start);
                unit_start  = start;
                unit_plen   = plen;
                unit_kind   = UT_OTHER;
                unit_open   = 1'b1;
                header_wait = 1'b1;
            end else if (header_wait) begin
                unit_kind   = header_class(b);
                header_wait = 1'b0;
            end
            if (b == 8'h00) begin
                if (zero_run != 2'd3)
                    zero_run++;
            end else begin
                zero_run = 2'd0;
            end
            byte_pos++;
            if (l) begin
                if (unit_open)
                    close_unit(byte_pos);
                restart();
            end
            if (expected_units.size() > n0)
                expected_units[$].run_last = 1'b1;
        endfunction

        function void compare(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
                failures++;
            end
        endfunction

        function void check_word(logic [OUT_TDATA_BITS-1:0] d, logic l);
            t_result e;
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %0h", $time, d);
                failures++;
                return;
            end
            e = expected_units.pop_front();
            compare("unit_offset", e.unit_offset, d[31:0]);
            compare("unit_size", e.unit_size, d[63:32]);
            compare("prefix_len", 32'(e.prefix_len), 32'(d[66:64]));
            compare("unit_type", 32'(e.unit_type), 32'(d[69:67]));
            compare("pad", 32'd0, 32'(d[OUT_TDATA_BITS-1:70]));
            compare("tlast", 32'(e.run_last), 32'(l));
        endfunction

        function int pending();
            return expected_units.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_wdata;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata;   // [7:0] data_byte
    logic                      i_s_axis_tlast;   // stream_end
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;   // unit_offset, unit_size, prefix_len,
                                                 // unit_type, zero pad
    logic                      o_m_axis_tlast;   // run_last

    unit_scoreboard sb = new();
    int             sent_bytes = 0;
    int             cycle_cnt  = 0;
    bit             idle_on    = 1'b1;
    bit             hold_req   = 1'b0;

    annexb_nal_unit_splitter_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, sb.pending());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        if (r == 2)
            return 8'h01;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= l;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_byte(b, l);
        sent_bytes++;
        if (sent_bytes == 400 || sent_bytes == 1000)
            hold_req = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_stream(input octet_q s);
        foreach (s[k])
            send_byte(s[k], k == s.size() - 1);
    endtask

    // bytes without an output can still be in flight, so keep waiting after no words are expected
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_codec(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        sb.codec = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic make_random_stream(output octet_q s);
        int units;
        int z;
        s = {};
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(4, 40)) s.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(0, 3)) s.push_back(noise_byte());
            units = $urandom_range(1, 7);
            for (int u = 0; u < units; u++) begin
                z = $urandom_range(0, 9);
                z = (z < 5) ? 2 : (z < 8) ? 3 : (z < 9) ? $urandom_range(4, 6) : 1;
                repeat (z) s.push_back(8'h00);
                s.push_back(8'h01);
                if (u == units - 1 && $urandom_range(0, 5) == 0)
                    break;
                if ($urandom_range(0, 9) != 0)
                    s.push_back($urandom_range(0, 2) != 0 ? HDR_BYTES[$urandom_range(0, 11)]
                                                           : 8'($urandom));
                repeat ($urandom_range(0, 10)) s.push_back(noise_byte());
            end
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) s.push_back(8'h00);
        end
    endtask

    // output side; long hold when requested so the input stalls
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            sb.check_word(o_m_axis_tdata, o_m_axis_tlast);
            @(negedge i_clk);
        end
    end

    initial begin
        octet_q s;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // H.264: leading junk, SPS, PPS after 4-byte code, long zero run,
        // unit whose header byte starts the next start code, header on the last byte
        write_codec(CODEC_H264);
        s = '{8'hAA, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h01, 8'h68,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06, 8'h00, 8'h00, 8'h01,
              8'h00, 8'h00, 8'h01, 8'hFF};
        send_stream(s);
        wait_idle();

        // H.265: VPS, IDR, zero header, start code on last byte, end with no unit
        write_codec(CODEC_H265);
        s = '{8'h00, 8'h00, 8'h01, 8'h40, 8'h00, 8'h00, 8'h01, 8'h26,
              8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01};
        send_stream(s);
        s = '{8'h55};
        send_stream(s);

        while (sent_bytes < TOTAL_BYTES) begin
            wait_idle();
            write_codec($urandom_range(0, 1));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) begin
                make_random_stream(s);
                send_stream(s);
            end
        end

        wait_idle();
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
